[hw/rtl/pss_pkg.sv]
// shared types and constants of the packed string set
package pss_pkg;

	// default sizes
	localparam int STORE_BYTES_DEF = 4096;
	localparam int MAX_PATH_DEF    = 63;

	// fixed field widths
	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 12;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ITER_FIRST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ITER_NEXT  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_ROOM  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] path_byte;
		logic              path_last;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] out_byte;
		logic              out_last;
		logic              at_end;
	} result_t;

endpackage

[hw/rtl/packed_string_set.sv]
// top level of the packed string set: sequencer over the byte store
//
// Path bytes of lookup, insert and delete are taken one per cycle with busy
// low and give no result. The item that carries path_last runs the operation:
// the store is walked entry by entry through its single registered read port.
// A new insert then copies the path byte by byte, and a delete moves every
// later byte down over the gap. Iteration replays the stored bytes of one
// entry. Each operation ends with a single result beat; iteration gives one
// beat per character, with out_last on the final one, and a single beat for
// an empty entry. Results are strobed by result_valid for one cycle and
// cannot be held off by the receiver; busy stays high until the last beat of
// an item goes out and is already low in the cycle that shows that beat.
module packed_string_set #(
	parameter int STORE_BYTES = pss_pkg::STORE_BYTES_DEF,
	parameter int MAX_PATH    = pss_pkg::MAX_PATH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pss_pkg::item_t   item,
	output logic             result_valid,
	output pss_pkg::result_t result
);
	import pss_pkg::*;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int LEN_W  = $clog2(MAX_PATH + 1);
	localparam int PA_W   = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_ENT,
		S_FIND_RD,
		S_FIND_CMP,
		S_FIND_DONE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_ITER_RD,
		S_ITER_CMP
	} state_t;

	state_t             state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [LEN_W-1:0]   len_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   iter_q;
	logic [CNT_W-1:0]   p_q;
	logic [CNT_W-1:0]   addr_q;
	logic [LEN_W-1:0]   k_q;
	logic               mm_q;
	logic               pend_q;
	logic [BYTE_W-1:0]  pend_byte_q;
	logic               result_valid_q;
	result_t            result_q;

	// memory ports
	logic               st_we;
	logic [ADDR_W-1:0]  st_waddr;
	logic [BYTE_W-1:0]  st_wdata;
	logic [BYTE_W-1:0]  st_rdata;
	logic               pb_we;
	logic [BYTE_W-1:0]  pb_rdata;

	// helper values
	logic               accept;
	logic [CNT_W-1:0]   len_ext;
	logic [CNT_W-1:0]   gap;
	logic               eoe;
	logic               room_ok;
	logic [CNT_W-1:0]   iter_start;
	logic               path_cmd;
	logic               ovf_next;

	function automatic result_t make_res(logic fnd, logic [CNT_W-1:0] pos,
		logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b, logic lst, logic ae);
		result_t r;
		r.found    = fnd;
		r.position = POS_W'(pos);
		r.status   = st;
		r.out_byte = b;
		r.out_last = lst;
		r.at_end   = ae;
		return r;
	endfunction

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign len_ext    = CNT_W'(len_q);
	assign gap        = len_ext + CNT_W'(1);
	assign eoe        = (addr_q >= used_q) || (st_rdata == '0);
	assign room_ok    = ((CNT_W+1)'(used_q) + (CNT_W+1)'(len_q) + (CNT_W+1)'(1))
		<= (CNT_W+1)'(STORE_BYTES);
	assign iter_start = (item.cmd == CMD_ITER_FIRST) ? '0 : iter_q;
	assign path_cmd   = (item.cmd == CMD_LOOKUP) || (item.cmd == CMD_INSERT)
		|| (item.cmd == CMD_DELETE);
	assign ovf_next   = ovf_q
		|| ((item.path_byte != '0) && (len_q == LEN_W'(MAX_PATH)));

	// path collection write
	assign pb_we = accept && path_cmd && (item.path_byte != '0)
		&& (len_q < LEN_W'(MAX_PATH));

	// store write port
	always_comb begin
		st_we    = 1'b0;
		st_waddr = addr_q[ADDR_W-1:0];
		st_wdata = pb_rdata;
		unique case (state_q)
			S_INS_RD: begin
				st_we    = (k_q == len_q);
				st_wdata = '0;
			end
			S_INS_WR: begin
				st_we = 1'b1;
			end
			S_DEL_WR: begin
				st_we    = 1'b1;
				st_waddr = ADDR_W'(addr_q - gap);
				st_wdata = st_rdata;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	pss_mem #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (addr_q[ADDR_W-1:0]),
		.rdata (st_rdata)
	);

	pss_mem #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PATH),
		.AW    (PA_W)
	) u_path (
		.clk   (clk),
		.we    (pb_we),
		.waddr (len_q[PA_W-1:0]),
		.wdata (item.path_byte),
		.raddr (k_q[PA_W-1:0]),
		.rdata (pb_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= '0;
			len_q          <= '0;
			ovf_q          <= 1'b0;
			used_q         <= '0;
			iter_q         <= '0;
			p_q            <= '0;
			addr_q         <= '0;
			k_q            <= '0;
			mm_q           <= 1'b0;
			pend_q         <= 1'b0;
			pend_byte_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= item.cmd;
						if (path_cmd) begin
							// collect path byte
							if (item.path_byte != '0) begin
								if (len_q < LEN_W'(MAX_PATH)) begin
									len_q <= len_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							if (item.path_last) begin
								if (ovf_next) begin
									result_valid_q <= 1'b1;
									result_q <= make_res(1'b0, '0, STATUS_TOO_LONG,
										'0, 1'b1, 1'b0);
									len_q <= '0;
									ovf_q <= 1'b0;
								end else begin
									p_q     <= '0;
									state_q <= S_FIND_ENT;
								end
							end
						end else if (item.cmd == CMD_ITER_FIRST ||
							item.cmd == CMD_ITER_NEXT) begin
							// start of iteration
							iter_q <= iter_start;
							if (iter_start >= used_q) begin
								result_valid_q <= 1'b1;
								result_q <= make_res(1'b0, '0, STATUS_OK, '0, 1'b1, 1'b1);
							end else begin
								p_q     <= iter_start;
								addr_q  <= iter_start;
								pend_q  <= 1'b0;
								state_q <= S_ITER_RD;
							end
						end
					end
				end
				S_FIND_ENT: begin
					// entry start: any room left for a match
					if ((p_q < used_q) && ((used_q - p_q) > len_ext)) begin
						addr_q  <= p_q;
						k_q     <= '0;
						mm_q    <= 1'b0;
						state_q <= S_FIND_RD;
					end else begin
						mm_q    <= 1'b1;
						state_q <= S_FIND_DONE;
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CMP;
				end
				S_FIND_CMP: begin
					// compare one stored byte against the path
					if (eoe) begin
						if (!mm_q && (k_q == len_q)) begin
							state_q <= S_FIND_DONE;
						end else begin
							p_q     <= addr_q + CNT_W'(1);
							state_q <= S_FIND_ENT;
						end
					end else begin
						if ((k_q >= len_q) || (st_rdata != pb_rdata)) begin
							mm_q <= 1'b1;
						end
						k_q     <= k_q + LEN_W'(1);
						addr_q  <= addr_q + CNT_W'(1);
						state_q <= S_FIND_RD;
					end
				end
				S_FIND_DONE: begin
					// mm_q low here means hit at p_q
					state_q <= S_IDLE;
					if (cmd_q == CMD_LOOKUP) begin
						result_valid_q <= 1'b1;
						result_q <= make_res(!mm_q, mm_q ? '0 : p_q, STATUS_OK,
							'0, 1'b1, 1'b0);
						len_q <= '0;
						ovf_q <= 1'b0;
					end else if (cmd_q == CMD_INSERT) begin
						if (!mm_q) begin
							result_valid_q <= 1'b1;
							result_q <= make_res(1'b1, p_q, STATUS_OK, '0, 1'b1, 1'b0);
							len_q <= '0;
							ovf_q <= 1'b0;
						end else if (!room_ok) begin
							result_valid_q <= 1'b1;
							result_q <= make_res(1'b0, '0, STATUS_NO_ROOM,
								'0, 1'b1, 1'b0);
							len_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							p_q     <= used_q;
							addr_q  <= used_q;
							k_q     <= '0;
							state_q <= S_INS_RD;
						end
					end else begin
						if (!mm_q) begin
							addr_q  <= p_q + gap;
							state_q <= S_DEL_RD;
						end else begin
							result_valid_q <= 1'b1;
							result_q <= make_res(1'b0, '0, STATUS_OK, '0, 1'b1, 1'b0);
							len_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				S_INS_RD: begin
					// terminator written by the write port on the last step
					if (k_q == len_q) begin
						used_q         <= addr_q + CNT_W'(1);
						result_valid_q <= 1'b1;
						result_q <= make_res(1'b0, p_q, STATUS_OK, '0, 1'b1, 1'b0);
						len_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					k_q     <= k_q + LEN_W'(1);
					addr_q  <= addr_q + CNT_W'(1);
					state_q <= S_INS_RD;
				end
				S_DEL_RD: begin
					// move tail bytes down over the gap
					if (addr_q >= used_q) begin
						used_q         <= used_q - gap;
						result_valid_q <= 1'b1;
						result_q <= make_res(1'b1, p_q, STATUS_OK, '0, 1'b1, 1'b0);
						len_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					addr_q  <= addr_q + CNT_W'(1);
					state_q <= S_DEL_RD;
				end
				S_ITER_RD: begin
					state_q <= S_ITER_CMP;
				end
				S_ITER_CMP: begin
					// one byte held back so the last beat can be marked
					if (eoe) begin
						result_valid_q <= 1'b1;
						result_q <= make_res(1'b0, p_q, STATUS_OK,
							pend_q ? pend_byte_q : '0, 1'b1, 1'b0);
						iter_q  <= addr_q + CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						if (pend_q) begin
							result_valid_q <= 1'b1;
							result_q <= make_res(1'b0, p_q, STATUS_OK, pend_byte_q,
								1'b0, 1'b0);
						end
						pend_q      <= 1'b1;
						pend_byte_q <= st_rdata;
						addr_q      <= addr_q + CNT_W'(1);
						state_q     <= S_ITER_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

[hw/rtl/pss_mem.sv]
// simple dual port ram, one write port and one registered read port
module pss_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/pss_checker.sv]
// port level checks of the packed string set, bound to the top level
module pss_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             result_valid,
	input pss_pkg::result_t result
);
	import pss_pkg::*;

	// final beat of an item frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_last |-> !busy)
		else $error("busy after final beat");

	// more beats pending keep the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_last |=> busy)
		else $error("idle with beats still pending");

	// end of iteration is a lone beat with no offset or character
	a_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.at_end |->
			result.out_last && (result.position == '0) && (result.out_byte == '0))
		else $error("bad end of iteration beat");

	// an error status never reports a hit
	a_err_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != STATUS_OK) |->
			!result.found && (result.position == '0))
		else $error("error status with hit");
endmodule

bind packed_string_set pss_checker u_pss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

[tb/sv/testbench.sv]
// testbench for the packed string set: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module testbench;
	import pss_pkg::*;

	localparam int STORE_SIZE = STORE_BYTES_DEF;
	localparam int PATH_MAX   = MAX_PATH_DEF;
	localparam int IDLE_LIMIT = 60000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	packed_string_set u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	// mirror of the block state
	logic [7:0] set_bytes [STORE_SIZE];
	int         set_used;
	int         walk_offset;
	logic [7:0] path_chars [PATH_MAX];
	int         path_len;
	bit         path_too_long;

	result_t answers [$];
	int      mismatches;
	int      idle_cycles;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int entry_length(int p);
		int e;
		e = 0;
		while (p + e < set_used && set_bytes[p + e] != 8'd0)
			e++;
		return e;
	endfunction

	// search the stored entries for the collected path
	function automatic bit locate_path(output int where);
		int  p;
		int  e;
		bit  same;
		p = 0;
		where = 0;
		while (p < set_used && set_used - p > path_len) begin
			e = entry_length(p);
			if (e == path_len) begin
				same = 1'b1;
				for (int k = 0; k < e; k++)
					if (set_bytes[p + k] != path_chars[k])
						same = 1'b0;
				if (same) begin
					where = p;
					return 1'b1;
				end
			end
			p += e + 1;
		end
		return 1'b0;
	endfunction

	function automatic result_t make_answer(bit f, int pos, logic [STAT_W-1:0] st,
		logic [7:0] b, bit lst, bit fin);
		result_t r;
		r.found    = f;
		r.position = pos[POS_W-1:0];
		r.status   = st;
		r.out_byte = b;
		r.out_last = lst;
		r.at_end   = fin;
		return r;
	endfunction

	// predicted effect of one accepted beat
	task automatic predict_beat(item_t it);
		int where;
		bit hit;
		int gap;
		int s;
		int e;
		if (it.cmd == CMD_LOOKUP || it.cmd == CMD_INSERT || it.cmd == CMD_DELETE) begin
			if (it.path_byte != 8'd0) begin
				if (path_len < PATH_MAX) begin
					path_chars[path_len] = it.path_byte;
					path_len++;
				end else
					path_too_long = 1'b1;
			end
			if (!it.path_last)
				return;
			if (path_too_long) begin
				answers.push_back(make_answer(1'b0, 0, STATUS_TOO_LONG, 8'd0, 1'b1, 1'b0));
			end else begin
				hit = locate_path(where);
				if (it.cmd == CMD_LOOKUP) begin
					answers.push_back(make_answer(hit, hit ? where : 0, STATUS_OK, 8'd0,
						1'b1, 1'b0));
				end else if (it.cmd == CMD_INSERT) begin
					if (hit)
						answers.push_back(make_answer(1'b1, where, STATUS_OK, 8'd0, 1'b1, 1'b0));
					else if (set_used + path_len + 1 > STORE_SIZE)
						answers.push_back(make_answer(1'b0, 0, STATUS_NO_ROOM, 8'd0,
							1'b1, 1'b0));
					else begin
						for (int k = 0; k < path_len; k++)
							set_bytes[set_used + k] = path_chars[k];
						set_bytes[set_used + path_len] = 8'd0;
						answers.push_back(make_answer(1'b0, set_used, STATUS_OK, 8'd0,
							1'b1, 1'b0));
						set_used += path_len + 1;
					end
				end else begin
					if (hit) begin
						gap = path_len + 1;
						for (int k = where; k < set_used - gap; k++)
							set_bytes[k] = set_bytes[k + gap];
						set_used -= gap;
						answers.push_back(make_answer(1'b1, where, STATUS_OK, 8'd0, 1'b1, 1'b0));
					end else
						answers.push_back(make_answer(1'b0, 0, STATUS_OK, 8'd0, 1'b1, 1'b0));
				end
			end
			path_len = 0;
			path_too_long = 1'b0;
		end else if (it.cmd == CMD_ITER_FIRST || it.cmd == CMD_ITER_NEXT) begin
			if (it.cmd == CMD_ITER_FIRST)
				walk_offset = 0;
			if (walk_offset >= set_used) begin
				answers.push_back(make_answer(1'b0, 0, STATUS_OK, 8'd0, 1'b1, 1'b1));
				return;
			end
			s = walk_offset;
			e = entry_length(s);
			walk_offset = s + e + 1;
			if (e > 64)
				e = 64;
			if (e == 0)
				answers.push_back(make_answer(1'b0, s, STATUS_OK, 8'd0, 1'b1, 1'b0));
			else
				for (int k = 0; k < e; k++)
					answers.push_back(make_answer(1'b0, s, STATUS_OK, set_bytes[s + k],
						k + 1 == e, 1'b0));
		end
	endtask

	// send one beat after a random gap; start stays high into the next beat
	task automatic send_beat(logic [CMD_W-1:0] c, logic [7:0] b, bit lst);
		int gap;
		item_t it;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: gap = 0;
			9:          gap = $urandom_range(10, 40);
			default:    gap = $urandom_range(1, 3);
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.cmd = c;
		it.path_byte = b;
		it.path_last = lst;
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		predict_beat(it);
	endtask

	task automatic send_path(logic [CMD_W-1:0] c, logic [7:0] chars [$]);
		if (chars.size() == 0) begin
			send_beat(c, 8'd0, 1'b1);
			return;
		end
		foreach (chars[k])
			send_beat(c, chars[k], k == chars.size() - 1);
	endtask

	// random path over a small alphabet so hits are common
	function automatic void pick_path(ref logic [7:0] chars [$]);
		int n;
		chars.delete();
		n = $urandom_range(0, 4);
		for (int k = 0; k < n; k++)
			if ($urandom_range(0, 7) == 0)
				chars.push_back(8'($urandom_range(1, 255)));
			else
				chars.push_back(8'(8'h61 + $urandom_range(0, 2)));
	endfunction

	// stop driving right after the last beat, then wait for all results
	task automatic drain();
		start <= 1'b0;
		while (answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (answers.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = answers.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d actual %0d", want.found, result.found);
					mismatches++;
				end
				if (result.position !== want.position) begin
					$error("position: expected %0d actual %0d", want.position, result.position);
					mismatches++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, result.status);
					mismatches++;
				end
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h actual %0h", want.out_byte, result.out_byte);
					mismatches++;
				end
				if (result.out_last !== want.out_last) begin
					$error("out_last: expected %0d actual %0d", want.out_last, result.out_last);
					mismatches++;
				end
				if (result.at_end !== want.at_end) begin
					$error("at_end: expected %0d actual %0d", want.at_end, result.at_end);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic test_empty_set();
		logic [7:0] p [$];
		send_beat(CMD_ITER_FIRST, 8'd0, 1'b0);
		send_beat(CMD_ITER_NEXT, 8'hff, 1'b1);
		p = {};
		send_path(CMD_LOOKUP, p);
		send_path(CMD_DELETE, p);
		p = {8'h61};
		send_path(CMD_DELETE, p);
	endtask

	task automatic test_basic_ops();
		logic [7:0] p [$];
		p = {8'h01, 8'hff, 8'h80};
		send_path(CMD_INSERT, p);
		send_path(CMD_LOOKUP, p);
		send_path(CMD_INSERT, p);
		p = {};
		send_path(CMD_INSERT, p);
		p = {8'h61, 8'h62};
		send_path(CMD_INSERT, p);
		// zero byte inside a path is skipped
		send_beat(CMD_LOOKUP, 8'h61, 1'b0);
		send_beat(CMD_LOOKUP, 8'h00, 1'b0);
		send_beat(CMD_LOOKUP, 8'h62, 1'b1);
		send_beat(CMD_ITER_FIRST, 8'd0, 1'b0);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		drain();
	endtask

	task automatic test_delete_mid_iteration();
		logic [7:0] p [$];
		send_beat(CMD_ITER_FIRST, 8'd0, 1'b0);
		p = {8'h01, 8'hff, 8'h80};
		send_path(CMD_DELETE, p);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		send_path(CMD_DELETE, p);
		drain();
	endtask

	// one byte past the path limit
	task automatic test_long_paths();
		logic [7:0] p [$];
		p = {};
		for (int k = 0; k < PATH_MAX + 1; k++)
			p.push_back(8'(8'h41 + k % 26));
		send_path(CMD_INSERT, p);
		send_beat(CMD_ITER_FIRST, 8'd0, 1'b0);
		drain();
	endtask

	task automatic test_unused_cmds();
		send_beat(3'd5, 8'h55, 1'b1);
		send_beat(3'd6, 8'haa, 1'b0);
		send_beat(3'd7, 8'hff, 1'b1);
		send_beat(CMD_ITER_NEXT, 8'd0, 1'b0);
		drain();
	endtask

	task automatic test_random_ops();
		logic [7:0] p [$];
		int pick;
		for (int n = 0; n < 30; n++) begin
			pick = $urandom_range(0, 18);
			pick_path(p);
			if (pick < 5)
				send_path(CMD_LOOKUP, p);
			else if (pick < 10)
				send_path(CMD_INSERT, p);
			else if (pick < 14)
				send_path(CMD_DELETE, p);
			else if (pick < 16)
				send_beat(CMD_ITER_FIRST, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			else if (pick < 18)
				send_beat(CMD_ITER_NEXT, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			else
				send_beat(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
		drain();
	endtask

	initial begin
		mismatches    = 0;
		set_used      = 0;
		walk_offset   = 0;
		path_len      = 0;
		path_too_long = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_set();
		test_basic_ops();
		test_delete_mid_iteration();
		test_long_paths();
		test_unused_cmds();
		test_random_ops();

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && answers.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[packed_string_set.f]
hw/rtl/pss_pkg.sv
hw/rtl/pss_mem.sv
hw/rtl/packed_string_set.sv
hw/rtl/pss_checker.sv
tb/sv/testbench.sv
